// ===== hdl/ssspe_pkg.sv =====
// ----------------------------------------------------------------------------
// ssspe_pkg
// Shared widths, codes and controller/datapath structs for the shortest path
// engine.
// ----------------------------------------------------------------------------
package ssspe_pkg;

   localparam int NODE_BITS      = 6;
   localparam int CNT_BITS       = 7;
   localparam int WEIGHT_IN_BITS = 16;
   localparam int RAW_BITS       = 32;
   localparam int DIST_BITS      = 32;
   localparam int DATA_BITS      = 32;
   localparam int ADDR_BITS      = 3;
   localparam int REG_IDX_BITS   = 1;

   localparam logic [DIST_BITS-1:0] DIST_MAX = 32'h7FFF_FFFF;
   localparam logic [DIST_BITS-1:0] DIST_MIN = 32'h8000_0000;

   // request codes
   localparam logic REQ_STORE = 1'b0;
   localparam logic REQ_RUN   = 1'b1;

   // register indexes
   localparam logic [REG_IDX_BITS-1:0] REG_NODE_COUNT  = 1'b0;
   localparam logic [REG_IDX_BITS-1:0] REG_SOURCE_NODE = 1'b1;

   typedef struct packed {
      logic store_edge;
      logic run_start;
      logic pass_begin;
      logic dist_read;
      logic relax;
      logic apply;
      logic pass_next;
      logic out_read;
      logic out_load;
      logic cycle_load;
      logic clear_edges;
   } ctrl_cmd_type;

   typedef struct packed {
      logic no_edges;
      logic last_edge;
      logic any_next;
      logic last_pass;
      logic last_node;
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== hdl/ssspe_if.sv =====
// ----------------------------------------------------------------------------
// ssspe_if
// Request and response channels of the shortest path engine.
// ----------------------------------------------------------------------------
interface ssspe_req_if;
   import ssspe_pkg::*;

   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic        [NODE_BITS-1:0]        from_node;
   logic        [NODE_BITS-1:0]        to_node;
   logic signed [WEIGHT_IN_BITS-1:0]   edge_weight;

   modport source (output valid, req_type, from_node, to_node, edge_weight, input ready);
   modport sink   (input valid, req_type, from_node, to_node, edge_weight, output ready);
endinterface

interface ssspe_rsp_if;
   import ssspe_pkg::*;

   logic                          valid;
   logic                          ready;
   logic        [NODE_BITS-1:0]   node_index;
   logic signed [DIST_BITS-1:0]   distance;
   logic                          reachable;
   logic                          negative_cycle;
   logic                          edges_dropped;
   logic                          last;

   modport source (output valid, node_index, distance, reachable, negative_cycle,
                   edges_dropped, last, input ready);
   modport sink   (input valid, node_index, distance, reachable, negative_cycle,
                   edges_dropped, last, output ready);
endinterface

// ===== hdl/ssspe_ram.sv =====
// ----------------------------------------------------------------------------
// ssspe_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ssspe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]                            rd_data_a,
   input  logic                                        rd_en_b,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                            rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== hdl/ssspe_csr.sv =====
// ----------------------------------------------------------------------------
// ssspe_csr
// APB register block holding node count and source node.
// ----------------------------------------------------------------------------
module ssspe_csr #(
   parameter int MAX_NODES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ssspe_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [ssspe_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [ssspe_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                            csr_pready,
   output logic [ssspe_pkg::CNT_BITS-1:0]  node_count,
   output logic [ssspe_pkg::NODE_BITS-1:0] source_node
);
   import ssspe_pkg::*;

   logic [CNT_BITS-1:0]     node_count_ff, node_count_in;
   logic [NODE_BITS-1:0]    source_node_ff, source_node_in;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    wr_beat;

   assign reg_idx    = csr_paddr[ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      node_count_in  = node_count_ff;
      source_node_in = source_node_ff;
      csr_prdata     = '0;
      case (reg_idx)
         REG_NODE_COUNT: begin
            csr_prdata = DATA_BITS'(node_count_ff);
            if (wr_beat) begin
               node_count_in = csr_pwdata[CNT_BITS-1:0];
            end
         end
         REG_SOURCE_NODE: begin
            csr_prdata = DATA_BITS'(source_node_ff);
            if (wr_beat) begin
               source_node_in = csr_pwdata[NODE_BITS-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= CNT_BITS'(MAX_NODES);
         source_node_ff <= '0;
      end else begin
         node_count_ff  <= node_count_in;
         source_node_ff <= source_node_in;
      end
   end

   assign node_count  = node_count_ff;
   assign source_node = source_node_ff;

endmodule

// ===== hdl/ssspe_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssspe_ctrl
// Sequencer: edge loading, relaxation passes, cycle check and result output.
// ----------------------------------------------------------------------------
module ssspe_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_type,
   output logic                             req_ready,
   input  ssspe_pkg::ctrl_status_type       status,
   output ssspe_pkg::ctrl_cmd_type          cmd
);
   import ssspe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS_START,
      ST_DIST_RD,
      ST_RELAX,
      ST_OUT_RD,
      ST_OUT_LOAD,
      ST_CYCLE_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      check_ff, check_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      check_in  = check_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_RUN) begin
                  cmd.run_start = 1'b1;
                  check_in      = 1'b0;
                  state_in      = ST_PASS_START;
               end else begin
                  cmd.store_edge = 1'b1;
               end
            end
         end
         ST_PASS_START: begin
            cmd.pass_begin = 1'b1;
            state_in       = status.no_edges ? ST_OUT_RD : ST_DIST_RD;
         end
         ST_DIST_RD: begin
            cmd.dist_read = 1'b1;
            state_in      = ST_RELAX;
         end
         ST_RELAX: begin
            cmd.relax = 1'b1;
            cmd.apply = !check_ff;
            if (!status.last_edge) begin
               state_in = ST_DIST_RD;
            end else if (check_ff) begin
               state_in = status.any_next ? ST_CYCLE_OUT : ST_OUT_RD;
            end else if (!status.any_next) begin
               // settled early: the check pass cannot find anything
               state_in = ST_OUT_RD;
            end else if (status.last_pass) begin
               check_in = 1'b1;
               state_in = ST_PASS_START;
            end else begin
               cmd.pass_next = 1'b1;
               state_in      = ST_PASS_START;
            end
         end
         ST_OUT_RD: begin
            cmd.out_read = 1'b1;
            state_in     = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.last_node) begin
                  cmd.clear_edges = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_CYCLE_OUT: begin
            if (status.out_free) begin
               cmd.cycle_load  = 1'b1;
               cmd.clear_edges = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         check_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         check_ff <= check_in;
      end
   end

   a_run_enters_pass : assert property (@(posedge clock) disable iff (reset)
      cmd.run_start |=> (state_ff == ST_PASS_START && !check_ff))
      else $error("run did not start a relaxation pass");

endmodule

// ===== hdl/ssspe_dp.sv =====
// ----------------------------------------------------------------------------
// ssspe_dp
// Datapath: edge store, distance store, reach marks, relax unit, result register.
// ----------------------------------------------------------------------------
module ssspe_dp #(
   parameter int MAX_NODES   = 64,
   parameter int MAX_EDGES   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  ssspe_pkg::ctrl_cmd_type                    cmd,
   output ssspe_pkg::ctrl_status_type                 status,
   input  logic [ssspe_pkg::CNT_BITS-1:0]             node_count,
   input  logic [ssspe_pkg::NODE_BITS-1:0]            source_node,
   input  logic [ssspe_pkg::NODE_BITS-1:0]            from_node,
   input  logic [ssspe_pkg::NODE_BITS-1:0]            to_node,
   input  logic signed [ssspe_pkg::WEIGHT_IN_BITS-1:0] edge_weight,
   ssspe_rsp_if.source                                rsp_bus
);
   import ssspe_pkg::*;

   localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int EDGE_W  = 2 * NODE_BITS + WEIGHT_BITS;

   // effective node count
   logic [CNT_BITS-1:0] n_eff;

   always_comb begin
      if (node_count == '0) begin
         n_eff = CNT_BITS'(1);
      end else if (node_count > CNT_BITS'(MAX_NODES)) begin
         n_eff = CNT_BITS'(MAX_NODES);
      end else begin
         n_eff = node_count;
      end
   end

   // edge store and counters
   logic [EDGE_CW-1:0]  edge_total_ff, edge_total_in;
   logic                overflow_ff, overflow_in;
   logic [EDGE_CW-1:0]  edge_idx_ff, edge_idx_in;
   logic [CNT_BITS-1:0] pass_cnt_ff, pass_cnt_in;
   logic [CNT_BITS-1:0] out_idx_ff, out_idx_in;
   logic                any_ff, any_in;
   logic [RAW_BITS-1:0] w_raw;
   logic                load_ok;
   logic                store_full;
   logic                edge_we;
   logic                edge_re;
   logic [EDGE_W-1:0]   edge_wdata;
   logic [EDGE_W-1:0]   edge_rdata;

   assign w_raw      = {{(RAW_BITS - WEIGHT_IN_BITS){1'b0}}, edge_weight};
   assign edge_wdata = {from_node, to_node, w_raw[WEIGHT_BITS-1:0]};
   assign load_ok    = ({1'b0, from_node} < n_eff) && ({1'b0, to_node} < n_eff);
   assign store_full = (edge_total_ff == EDGE_CW'(MAX_EDGES));
   assign edge_we    = cmd.store_edge && load_ok && !store_full;
   assign edge_re    = cmd.pass_begin || cmd.relax;

   ssspe_ram #(
      .WIDTH (EDGE_W),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock     (clock),
      .wr_en     (edge_we),
      .wr_addr   (edge_total_ff[EDGE_AW-1:0]),
      .wr_data   (edge_wdata),
      .rd_en_a   (edge_re),
      .rd_addr_a (edge_idx_in[EDGE_AW-1:0]),
      .rd_data_a (edge_rdata),
      .rd_en_b   (1'b0),
      .rd_addr_b ('0),
      .rd_data_b ()
   );

   // fields of the edge under relaxation
   logic [NODE_BITS-1:0]   e_u;
   logic [NODE_BITS-1:0]   e_v;
   logic [WEIGHT_BITS-1:0] e_w;
   logic                   edge_ok;

   assign e_u     = edge_rdata[EDGE_W-1 -: NODE_BITS];
   assign e_v     = edge_rdata[WEIGHT_BITS +: NODE_BITS];
   assign e_w     = edge_rdata[WEIGHT_BITS-1:0];
   assign edge_ok = ({1'b0, e_u} < n_eff) && ({1'b0, e_v} < n_eff);

   // distance store
   logic [MAX_NODES-1:0]  reach_ff, reach_in;
   logic                  src_ok;
   logic                  dist_we;
   logic [NODE_AW-1:0]    dist_waddr;
   logic [DIST_BITS-1:0]  dist_wdata;
   logic                  dist_re_a;
   logic [NODE_AW-1:0]    dist_raddr_a;
   logic [DIST_BITS-1:0]  dist_a;
   logic [DIST_BITS-1:0]  dist_b;
   logic signed [DIST_BITS:0] du_ext;
   logic signed [DIST_BITS:0] dv_ext;
   logic signed [DIST_BITS:0] w_ext;
   logic signed [DIST_BITS:0] cand;
   logic [DIST_BITS-1:0]  cand_sat;
   logic                  reach_u;
   logic                  reach_v;
   logic                  improve;

   assign src_ok  = ({1'b0, source_node} < n_eff);
   assign reach_u = reach_ff[e_u[NODE_AW-1:0]];
   assign reach_v = reach_ff[e_v[NODE_AW-1:0]];
   assign du_ext  = (DIST_BITS + 1)'($signed(dist_a));
   assign dv_ext  = (DIST_BITS + 1)'($signed(dist_b));
   assign w_ext   = (DIST_BITS + 1)'($signed(e_w));
   assign cand    = du_ext + w_ext;
   assign improve = edge_ok && reach_u && (!reach_v || (cand < dv_ext));

   always_comb begin
      if (cand[DIST_BITS] != cand[DIST_BITS-1]) begin
         cand_sat = cand[DIST_BITS] ? DIST_MIN : DIST_MAX;
      end else begin
         cand_sat = cand[DIST_BITS-1:0];
      end
   end

   always_comb begin
      dist_we    = 1'b0;
      dist_waddr = e_v[NODE_AW-1:0];
      dist_wdata = cand_sat;
      if (cmd.run_start) begin
         dist_we    = src_ok;
         dist_waddr = source_node[NODE_AW-1:0];
         dist_wdata = '0;
      end else if (cmd.relax && cmd.apply) begin
         dist_we = improve;
      end
   end

   assign dist_re_a    = cmd.dist_read || cmd.out_read;
   assign dist_raddr_a = cmd.out_read ? out_idx_ff[NODE_AW-1:0] : e_u[NODE_AW-1:0];

   ssspe_ram #(
      .WIDTH (DIST_BITS),
      .DEPTH (MAX_NODES)
   ) u_dist_ram (
      .clock     (clock),
      .wr_en     (dist_we),
      .wr_addr   (dist_waddr),
      .wr_data   (dist_wdata),
      .rd_en_a   (dist_re_a),
      .rd_addr_a (dist_raddr_a),
      .rd_data_a (dist_a),
      .rd_en_b   (cmd.dist_read),
      .rd_addr_b (e_v[NODE_AW-1:0]),
      .rd_data_b (dist_b)
   );

   // counters and marks
   always_comb begin
      edge_total_in = edge_total_ff;
      overflow_in   = overflow_ff;
      edge_idx_in   = edge_idx_ff;
      pass_cnt_in   = pass_cnt_ff;
      out_idx_in    = out_idx_ff;
      any_in        = any_ff;
      reach_in      = reach_ff;

      if (cmd.clear_edges) begin
         edge_total_in = '0;
         overflow_in   = 1'b0;
      end else if (cmd.store_edge && load_ok) begin
         if (store_full) begin
            overflow_in = 1'b1;
         end else begin
            edge_total_in = edge_total_ff + EDGE_CW'(1);
         end
      end

      if (cmd.run_start) begin
         reach_in    = '0;
         pass_cnt_in = '0;
         out_idx_in  = '0;
         if (src_ok) begin
            reach_in[source_node[NODE_AW-1:0]] = 1'b1;
         end
      end
      if (cmd.pass_begin) begin
         edge_idx_in = '0;
         any_in      = 1'b0;
      end
      if (cmd.relax) begin
         edge_idx_in = edge_idx_ff + EDGE_CW'(1);
         any_in      = any_ff || improve;
         if (cmd.apply && improve) begin
            reach_in[e_v[NODE_AW-1:0]] = 1'b1;
         end
      end
      if (cmd.pass_next) begin
         pass_cnt_in = pass_cnt_ff + CNT_BITS'(1);
      end
      if (cmd.out_load) begin
         out_idx_in = out_idx_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
         overflow_ff   <= 1'b0;
         edge_idx_ff   <= '0;
         pass_cnt_ff   <= '0;
         out_idx_ff    <= '0;
         any_ff        <= 1'b0;
      end else begin
         edge_total_ff <= edge_total_in;
         overflow_ff   <= overflow_in;
         edge_idx_ff   <= edge_idx_in;
         pass_cnt_ff   <= pass_cnt_in;
         out_idx_ff    <= out_idx_in;
         any_ff        <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      reach_ff <= reach_in;
   end

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_BITS-1:0] rsp_node_ff;
   logic [DIST_BITS-1:0] rsp_dist_ff;
   logic                 rsp_reach_ff;
   logic                 rsp_cycle_ff;
   logic                 rsp_dropped_ff;
   logic                 rsp_last_ff;
   logic                 out_reach;

   assign out_reach = reach_ff[out_idx_ff[NODE_AW-1:0]];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load || cmd.cycle_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_node_ff    <= out_idx_ff[NODE_BITS-1:0];
         rsp_dist_ff    <= out_reach ? dist_a : '0;
         rsp_reach_ff   <= out_reach;
         rsp_cycle_ff   <= 1'b0;
         rsp_dropped_ff <= overflow_ff;
         rsp_last_ff    <= status.last_node;
      end else if (cmd.cycle_load) begin
         rsp_node_ff    <= '0;
         rsp_dist_ff    <= '0;
         rsp_reach_ff   <= 1'b0;
         rsp_cycle_ff   <= 1'b1;
         rsp_dropped_ff <= overflow_ff;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.node_index     = rsp_node_ff;
   assign rsp_bus.distance       = rsp_dist_ff;
   assign rsp_bus.reachable      = rsp_reach_ff;
   assign rsp_bus.negative_cycle = rsp_cycle_ff;
   assign rsp_bus.edges_dropped  = rsp_dropped_ff;
   assign rsp_bus.last           = rsp_last_ff;

   // status back to the sequencer
   always_comb begin
      status.no_edges  = (edge_total_ff == '0);
      status.last_edge = ((edge_idx_ff + EDGE_CW'(1)) == edge_total_ff);
      status.any_next  = any_ff || improve;
      status.last_pass = ((pass_cnt_ff + CNT_BITS'(1)) == n_eff);
      status.last_node = ((out_idx_ff + CNT_BITS'(1)) == n_eff);
      status.out_free  = !rsp_valid_ff || rsp_bus.ready;
   end

   a_edge_total_bound : assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= EDGE_CW'(MAX_EDGES))
      else $error("edge count beyond store size");

   a_clear_after_run : assert property (@(posedge clock) disable iff (reset)
      cmd.clear_edges |=> (edge_total_ff == '0 && !overflow_ff))
      else $error("edge list not emptied after run");

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load || cmd.cycle_load) |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result register overwritten while still held");

endmodule

// ===== hdl/single_source_shortest_path_engine_top.sv =====
// edge load beat: accepted one per cycle while the controller is idle, takes effect in the same cycle
// run beat: up to (n + 1) passes over the edge list, n = effective node count;
//    each edge gets a distance read state, then a relax/write state
// results: per node beat, a distance store read, then the result register
// reset clears the edge count, drop flag, controller and registers to defaults;
//    the edge and distance stores need no clearing
// ----------------------------------------------------------------------------
// single_source_shortest_path_engine_top
// Bellman-Ford shortest path engine with APB configuration registers.
// ----------------------------------------------------------------------------
module single_source_shortest_path_engine_top #(
   parameter int MAX_NODES   = 64,
   parameter int MAX_EDGES   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   ssspe_req_if.sink                       req_bus,
   ssspe_rsp_if.source                     rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ssspe_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [ssspe_pkg::DATA_BITS-1:0] csr_pwdata,
   output logic [ssspe_pkg::DATA_BITS-1:0] csr_prdata,
   output logic                            csr_pready
);
   import ssspe_pkg::*;

   logic [CNT_BITS-1:0]  node_count;
   logic [NODE_BITS-1:0] source_node;
   logic                 req_ready;
   ctrl_cmd_type         cmd;
   ctrl_status_type      status;

   ssspe_csr #(
      .MAX_NODES (MAX_NODES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .node_count  (node_count),
      .source_node (source_node)
   );

   ssspe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = req_ready;

   ssspe_dp #(
      .MAX_NODES   (MAX_NODES),
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .node_count  (node_count),
      .source_node (source_node),
      .from_node   (req_bus.from_node),
      .to_node     (req_bus.to_node),
      .edge_weight (req_bus.edge_weight),
      .rsp_bus     (rsp_bus)
   );

endmodule
